### hdl/fpf_pkg.sv
// ----------------------------------------------------------------------------
// fpf_pkg
// Shared constants and types for the frame protocol port filter.
// ----------------------------------------------------------------------------
package fpf_pkg;

    localparam int OFFSET_BITS = 11;

    localparam logic [15:0] KIND_IPV4 = 16'h0800;
    localparam logic [15:0] KIND_IPV6 = 16'h86DD;
    localparam logic [15:0] KIND_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_DNS   = 16'd53;

    localparam logic [6:0] V6_L4_START = 7'd54;

    // Filter mode codes; any other code rejects everything
    localparam logic [2:0] MODE_HTTP  = 3'd1;
    localparam logic [2:0] MODE_HTTPS = 3'd2;
    localparam logic [2:0] MODE_DNS   = 3'd3;
    localparam logic [2:0] MODE_ARP   = 3'd4;
    localparam logic [2:0] MODE_TCP   = 3'd5;
    localparam logic [2:0] MODE_UDP   = 3'd6;

    // Frame record queue
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = 1;

    // Classified frame, handed from parser to verdict stage
    typedef struct packed {
        logic        seen_kind;
        logic        seen_proto;
        logic        seen_ports;
        logic        is_arp;
        logic        is_ip;
        logic        is_tcp;
        logic        is_udp;
        logic [15:0] match_port;
    } t_fpf_rec;

endpackage

### hdl/fpf_parser.sv
// ----------------------------------------------------------------------------
// fpf_parser
// Front end: take frame bytes, capture header fields, classify each frame.
// ----------------------------------------------------------------------------
module fpf_parser import fpf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_frame_byte,
    input  logic       i_end_of_frame,
    input  logic       i_q_full,
    output logic       o_push,
    output t_fpf_rec   o_rec
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [OFFSET_BITS-1:0] r_byte_offset, n_byte_offset;
    logic [15:0]            r_ether_kind, n_ether_kind;
    logic [2:0]             r_fields_seen, n_fields_seen;
    logic [6:0]             r_l4_start, n_l4_start;
    logic [7:0]             r_l4_protocol, n_l4_protocol;
    logic [15:0]            r_source_port, n_source_port;
    logic [15:0]            r_dest_port, n_dest_port;

    logic                   take;
    logic                   is_v4;
    logic                   is_v6;
    logic [OFFSET_BITS-1:0] l4_ext;
    logic [OFFSET_BITS-1:0] l4_pos;
    logic                   in_l4;

    assign o_in_ready = !i_q_full;
    assign take       = i_in_valid && o_in_ready;
    assign o_push     = take && i_end_of_frame;

    always_comb begin
        n_ether_kind  = r_ether_kind;
        n_fields_seen = r_fields_seen;
        n_l4_start    = r_l4_start;
        n_l4_protocol = r_l4_protocol;
        n_source_port = r_source_port;
        n_dest_port   = r_dest_port;

        if (r_byte_offset == OFFSET_BITS'(12)) begin
            n_ether_kind = {i_frame_byte, 8'h00};
        end
        if (r_byte_offset == OFFSET_BITS'(13)) begin
            n_ether_kind     = {r_ether_kind[15:8], i_frame_byte};
            n_fields_seen[0] = 1'b1;
            if (n_ether_kind == KIND_IPV6) begin
                n_l4_start = V6_L4_START;
            end
        end

        is_v4 = n_fields_seen[0] && (n_ether_kind == KIND_IPV4);
        is_v6 = n_fields_seen[0] && (n_ether_kind == KIND_IPV6);

        // Header length in words sets where the transport header starts
        if (is_v4 && r_byte_offset == OFFSET_BITS'(14)) begin
            n_l4_start = 7'd14 + {1'b0, i_frame_byte[3:0], 2'b00};
        end
        if ((is_v4 && r_byte_offset == OFFSET_BITS'(23)) ||
            (is_v6 && r_byte_offset == OFFSET_BITS'(20))) begin
            n_l4_protocol    = i_frame_byte;
            n_fields_seen[1] = 1'b1;
        end

        l4_ext = OFFSET_BITS'(n_l4_start);
        l4_pos = r_byte_offset - l4_ext;
        in_l4  = (is_v4 || is_v6) && (r_byte_offset >= OFFSET_BITS'(14)) &&
                 (r_byte_offset >= l4_ext) && (l4_pos < OFFSET_BITS'(4));
        if (in_l4) begin
            case (l4_pos[1:0])
                2'd0: n_source_port = {i_frame_byte, r_source_port[7:0]};
                2'd1: n_source_port = {r_source_port[15:8], i_frame_byte};
                2'd2: n_dest_port   = {i_frame_byte, r_dest_port[7:0]};
                2'd3: begin
                    n_dest_port      = {r_dest_port[15:8], i_frame_byte};
                    n_fields_seen[2] = 1'b1;
                end
                default: n_dest_port = r_dest_port;
            endcase
        end

        // Saturate offset on long frames
        n_byte_offset = (r_byte_offset == OFF_MAX) ? r_byte_offset
                                                   : r_byte_offset + 1'b1;

        o_rec.seen_kind  = n_fields_seen[0];
        o_rec.seen_proto = n_fields_seen[1];
        o_rec.seen_ports = n_fields_seen[2];
        o_rec.is_arp     = n_ether_kind == KIND_ARP;
        o_rec.is_ip      = (n_ether_kind == KIND_IPV4) || (n_ether_kind == KIND_IPV6);
        o_rec.is_tcp     = n_l4_protocol == PROTO_TCP;
        o_rec.is_udp     = n_l4_protocol == PROTO_UDP;
        o_rec.match_port = o_rec.is_tcp ? n_dest_port : n_source_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_byte_offset <= '0;
            r_ether_kind  <= '0;
            r_fields_seen <= '0;
            r_l4_start    <= '0;
            r_l4_protocol <= '0;
            r_source_port <= '0;
            r_dest_port   <= '0;
        end else if (take) begin
            r_byte_offset <= n_byte_offset;
            r_ether_kind  <= n_ether_kind;
            r_fields_seen <= n_fields_seen;
            r_l4_start    <= n_l4_start;
            r_l4_protocol <= n_l4_protocol;
            r_source_port <= n_source_port;
            r_dest_port   <= n_dest_port;
        end
    end

endmodule

### hdl/fpf_queue.sv
// ----------------------------------------------------------------------------
// fpf_queue
// Short queue of classified frames between parser and verdict stage.
// ----------------------------------------------------------------------------
module fpf_queue import fpf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_fpf_rec i_rec,
    input  logic     i_pop,
    output t_fpf_rec o_rec,
    output logic     o_full,
    output logic     o_not_empty
);

    t_fpf_rec               r_mem [QDEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr;
    logic [QPTR_BITS:0]     r_count;

    assign o_full      = r_count == (QPTR_BITS+1)'(QDEPTH);
    assign o_not_empty = r_count != '0;
    assign o_rec       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/fpf_verdict.sv
// ----------------------------------------------------------------------------
// fpf_verdict
// Back end: apply the filter mode to a classified frame, hold the result.
// ----------------------------------------------------------------------------
module fpf_verdict import fpf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_filter_mode,
    input  logic       i_q_not_empty,
    input  t_fpf_rec   i_rec,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_accept,
    output logic       o_short_frame
);

    logic        r_out_valid;
    logic        r_accept;
    logic        r_short_frame;
    logic        n_accept;
    logic        n_short_frame;
    logic [15:0] want_port;
    logic        port_mode;

    assign o_pop         = i_q_not_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid   = r_out_valid;
    assign o_accept      = r_accept;
    assign o_short_frame = r_short_frame;

    always_comb begin
        port_mode = 1'b0;
        want_port = PORT_DNS;
        case (i_filter_mode)
            MODE_HTTP:  begin port_mode = 1'b1; want_port = PORT_HTTP;  end
            MODE_HTTPS: begin port_mode = 1'b1; want_port = PORT_HTTPS; end
            MODE_DNS:   begin port_mode = 1'b1; want_port = PORT_DNS;   end
            default:    port_mode = 1'b0;
        endcase

        n_accept      = 1'b0;
        n_short_frame = 1'b0;
        if (port_mode || i_filter_mode == MODE_ARP || i_filter_mode == MODE_TCP ||
            i_filter_mode == MODE_UDP) begin
            if (!i_rec.seen_kind) begin
                n_short_frame = 1'b1;
            end else if (i_filter_mode == MODE_ARP) begin
                n_accept = i_rec.is_arp;
            end else if (i_rec.is_ip) begin
                if (!i_rec.seen_proto) begin
                    n_short_frame = 1'b1;
                end else if (i_filter_mode == MODE_TCP) begin
                    n_accept = i_rec.is_tcp;
                end else if (i_filter_mode == MODE_UDP) begin
                    n_accept = i_rec.is_udp;
                end else if (i_rec.is_tcp || i_rec.is_udp) begin
                    if (!i_rec.seen_ports) begin
                        n_short_frame = 1'b1;
                    end else begin
                        n_accept = i_rec.match_port == want_port;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_accept      <= n_accept;
            r_short_frame <= n_short_frame;
        end
    end

endmodule

### hdl/frame_protocol_port_filter_top.sv
// ----------------------------------------------------------------------------
// frame_protocol_port_filter_top
// Ethernet frame filter: one verdict per frame on EtherType, IP protocol
// and transport port, for a configurable filter mode.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  --------  ---------  -----------------------  -------------------------------
//  in        sink       i_in_valid / o_in_ready  i_frame_byte, i_end_of_frame
//  out       source     o_out_valid/ i_out_ready o_accept, o_short_frame
//  cfg       sink       i_cfg_valid/ o_cfg_ready i_cfg_filter_mode
//
//  Throughput is one byte per cycle while the queue is not full; the parser
//  updates its capture registers in the cycle the byte is taken.
//  The edge that takes the last byte of a frame pushes the frame record into
//  the queue; the output register loads it from the queue once that register
//  is free.
//  A two-entry frame queue sits between parser and verdict stage, so bytes
//  keep flowing while a verdict waits; o_in_ready drops only when the queue
//  is full. Configuration is always ready.
//  Reset is synchronous, active low, and clears the mode, parser and queue.
//
module frame_protocol_port_filter_top import fpf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_frame_byte,
    input  logic       i_end_of_frame,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_accept,
    output logic       o_short_frame,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_filter_mode
);

    logic [2:0] r_filter_mode;
    logic       q_full;
    logic       q_not_empty;
    logic       push;
    logic       pop;
    t_fpf_rec   rec_in;
    t_fpf_rec   rec_out;

    // Mode register: always ready; the verdict stage reads it when a frame
    // leaves the queue, so change it only while no frame is in flight
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_filter_mode <= i_cfg_filter_mode;
        end
    end

    // Front: parse bytes, push one classified record per frame
    fpf_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_frame_byte   (i_frame_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_rec          (rec_in)
    );

    // Decouple front and back
    fpf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rec       (rec_in),
        .i_pop       (pop),
        .o_rec       (rec_out),
        .o_full      (q_full),
        .o_not_empty (q_not_empty)
    );

    // Back: apply mode, hold result until taken
    fpf_verdict u_verdict (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_filter_mode (r_filter_mode),
        .i_q_not_empty (q_not_empty),
        .i_rec         (rec_out),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_accept      (o_accept),
        .o_short_frame (o_short_frame)
    );

endmodule

### hdl/fpf_checker.sv
// ----------------------------------------------------------------------------
// fpf_checker
// Port-level checks for the frame protocol port filter.
// ----------------------------------------------------------------------------
module fpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_end_of_frame,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_accept,
    input logic       o_short_frame
);

    // Frames ended but not yet answered
    logic [2:0] r_pending;
    logic       frame_end;
    logic       result_taken;

    assign frame_end    = i_in_valid && o_in_ready && i_end_of_frame;
    assign result_taken = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({frame_end, result_taken})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    a_result_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 3'd0)
        else $error("result without a finished frame");

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 3'd3 |-> !o_in_ready)
        else $error("input taken with queue and output full");

    a_short_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accept && o_short_frame))
        else $error("short frame reported as accepted");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_accept) && $stable(o_short_frame))
        else $error("stalled result changed");

endmodule

bind frame_protocol_port_filter_top fpf_checker u_fpf_checker (.*);

### test/frame_protocol_port_filter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_protocol_port_filter_top_test
// Self-checking bench for the frame protocol port filter. Streams Ethernet
// frames byte by byte under every filter mode and checks each frame verdict
// against a cycle-free model of the parser and the filter rules.
// ----------------------------------------------------------------------------
module frame_protocol_port_filter_top_test;
    import fpf_pkg::*;

    // Modes that reject every frame
    localparam logic [2:0] MODE_OFF_LO = 3'd0;
    localparam logic [2:0] MODE_OFF_HI = 3'd7;

    // Capture flags, one bit per header field group
    localparam int SEEN_KIND_BIT  = 0;
    localparam int SEEN_PROTO_BIT = 1;
    localparam int SEEN_PORTS_BIT = 2;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    localparam int NUM_SETTINGS  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEG_BYTES     = 115;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_item;

    typedef struct packed {
        logic accept;
        logic short_frame;
    } t_frame_verdict;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_frame_byte = 8'h00;
    logic       i_end_of_frame = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_accept;
    logic       o_short_frame;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_filter_mode = 3'd0;

    frame_protocol_port_filter_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_frame_byte      (i_frame_byte),
        .i_end_of_frame    (i_end_of_frame),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_accept          (o_accept),
        .o_short_frame     (o_short_frame),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_filter_mode (i_cfg_filter_mode)
    );

    // Stimulus and scoreboard storage
    t_frame_item    pending_bytes[$];
    t_frame_verdict expected_verdicts[$];
    t_frame_item    next_item;

    // Idle percentages for each side, changed only at the falling edge
    int in_idle_pct  = 0;
    int out_idle_pct = 0;

    int error_count    = 0;
    int bytes_taken    = 0;
    int frames_checked = 0;
    int accepts_seen   = 0;
    int shorts_seen    = 0;
    int cycle_count    = 0;

    // Parser state of the filter model
    logic [2:0]             active_mode = 3'd0;
    logic [OFFSET_BITS-1:0] pos_count   = '0;
    logic [15:0]            eth_type    = '0;
    logic [3:0]             hdr_words   = '0;
    logic [7:0]             ip_proto    = '0;
    logic [6:0]             ports_at    = '0;
    logic [15:0]            src_port    = '0;
    logic [15:0]            dest_port   = '0;
    logic [2:0]             got_flags   = '0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------

    // Apply the filter rules for the current mode to the captured fields
    function automatic t_frame_verdict judge_frame();
        t_frame_verdict v;
        logic           is_tcp;
        logic           is_udp;
        logic [15:0]    want;
        v = '0;
        if (active_mode == MODE_OFF_LO || active_mode == MODE_OFF_HI) return v;
        if (!got_flags[SEEN_KIND_BIT]) begin
            v.short_frame = 1'b1;
            return v;
        end
        if (active_mode == MODE_ARP) begin
            v.accept = (eth_type == KIND_ARP);
            return v;
        end
        if (eth_type != KIND_IPV4 && eth_type != KIND_IPV6) return v;
        if (!got_flags[SEEN_PROTO_BIT]) begin
            v.short_frame = 1'b1;
            return v;
        end
        is_tcp = (ip_proto == PROTO_TCP);
        is_udp = (ip_proto == PROTO_UDP);
        if (active_mode == MODE_TCP) begin
            v.accept = is_tcp;
            return v;
        end
        if (active_mode == MODE_UDP) begin
            v.accept = is_udp;
            return v;
        end
        if (!is_tcp && !is_udp) return v;
        if (!got_flags[SEEN_PORTS_BIT]) begin
            v.short_frame = 1'b1;
            return v;
        end
        case (active_mode)
            MODE_HTTP:  want = PORT_HTTP;
            MODE_HTTPS: want = PORT_HTTPS;
            default:    want = PORT_DNS;
        endcase
        // TCP matches on the destination port, UDP on the source port
        v.accept = ((is_tcp ? dest_port : src_port) == want);
        return v;
    endfunction

    // Advance the model by one accepted byte; queue a verdict on the last one
    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic                   is_v4;
        logic                   is_v6;
        logic [OFFSET_BITS-1:0] rel;
        if (pos_count == 12) eth_type = {b, 8'h00};
        if (pos_count == 13) begin
            eth_type[7:0] = b;
            got_flags[SEEN_KIND_BIT] = 1'b1;
            if (eth_type == KIND_IPV6) ports_at = V6_L4_START;
        end
        is_v4 = got_flags[SEEN_KIND_BIT] && eth_type == KIND_IPV4;
        is_v6 = got_flags[SEEN_KIND_BIT] && eth_type == KIND_IPV6;

        if (is_v4 && pos_count == 14) begin
            hdr_words = b[3:0];
            ports_at  = 7'(14 + 4 * hdr_words);
        end
        if ((is_v4 && pos_count == 23) || (is_v6 && pos_count == 20)) begin
            ip_proto = b;
            got_flags[SEEN_PROTO_BIT] = 1'b1;
        end
        // A short IPv4 header lets the port window overlap header bytes
        if ((is_v4 || is_v6) && pos_count >= 14 && pos_count >= ports_at) begin
            rel = pos_count - OFFSET_BITS'(ports_at);
            case (rel)
                0: src_port[15:8] = b;
                1: src_port[7:0]  = b;
                2: dest_port[15:8] = b;
                3: begin
                    dest_port[7:0] = b;
                    got_flags[SEEN_PORTS_BIT] = 1'b1;
                end
                default: ;
            endcase
        end
        // Saturate the offset on very long frames
        if (pos_count != OFFSET_MAX) pos_count = pos_count + 1'b1;

        if (last) begin
            expected_verdicts.push_back(judge_frame());
            pos_count = '0;
            eth_type  = '0;
            hdr_words = '0;
            ip_proto  = '0;
            ports_at  = '0;
            src_port  = '0;
            dest_port = '0;
            got_flags = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Byte driver: hold the item until taken, then load the next one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_byte(i_frame_byte, i_end_of_frame);
                bytes_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    next_item = pending_bytes.pop_front();
                    i_in_valid     <= 1'b1;
                    i_frame_byte   <= next_item.data;
                    i_end_of_frame <= next_item.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict monitor: compare each taken verdict with the oldest expected
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_verdict exp_v;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("verdict with no frame pending: accept %0d short_frame %0d",
                           o_accept, o_short_frame);
                    error_count++;
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    frames_checked++;
                    if (o_accept) accepts_seen++;
                    if (o_short_frame) shorts_seen++;
                    if (o_accept !== exp_v.accept) begin
                        $error("accept mismatch: expected %0d, got %0d",
                               exp_v.accept, o_accept);
                        error_count++;
                    end
                    if (o_short_frame !== exp_v.short_frame) begin
                        $error("short_frame mismatch: expected %0d, got %0d",
                               exp_v.short_frame, o_short_frame);
                        error_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Watchdog: stop a run that hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Favor the filtered ports so every port mode sees hits and misses
    function automatic logic [15:0] pick_port();
        case ($urandom_range(9))
            0, 1:    return PORT_HTTP;
            2, 3:    return PORT_HTTPS;
            4, 5:    return PORT_DNS;
            6:       return {PORT_HTTP[7:0], PORT_HTTP[15:8]};
            7:       return 16'hFFFF;
            8:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build one frame with random content and queue its bytes
    task automatic queue_frame(output int frame_len);
        logic [7:0]  body[];
        logic [15:0] kind;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [3:0]  words;
        int          pick;
        int          l4;
        int          need;
        int          full;
        t_frame_item it;
        pick = $urandom_range(99);
        if (pick < 45)      kind = KIND_IPV4;
        else if (pick < 60) kind = KIND_IPV6;
        else if (pick < 75) kind = KIND_ARP;
        else if (pick < 88) kind = 16'($urandom);
        else kind = ($urandom_range(1) ? KIND_IPV4 : KIND_IPV6) ^ (16'h1 << $urandom_range(15));

        // Mostly a plain 20-byte header, sometimes any length nibble
        words = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd5;
        pick = $urandom_range(99);
        if (pick < 40)      proto = PROTO_TCP;
        else if (pick < 80) proto = PROTO_UDP;
        else                proto = 8'($urandom);
        sport = pick_port();
        dport = pick_port();

        l4   = (kind == KIND_IPV6) ? int'(V6_L4_START) : 14 + 4 * words;
        need = (kind == KIND_IPV4) ? 24 : ((kind == KIND_IPV6) ? 21 : 14);
        full = ((l4 + 4 > need) ? l4 + 4 : need) + $urandom_range(8);
        // Cut one frame in five short at a random point
        if ($urandom_range(4) == 0) frame_len = $urandom_range(full, 1);
        else                        frame_len = full;

        body = new[full];
        foreach (body[k]) body[k] = 8'($urandom);
        body[l4]     = sport[15:8];
        body[l4 + 1] = sport[7:0];
        body[l4 + 2] = dport[15:8];
        body[l4 + 3] = dport[7:0];
        body[12] = kind[15:8];
        body[13] = kind[7:0];
        if (kind == KIND_IPV4) begin
            body[14] = {4'($urandom_range(15)), words};
            body[23] = proto;
        end
        if (kind == KIND_IPV6) body[20] = proto;

        for (int k = 0; k < frame_len; k++) begin
            it.data = body[k];
            it.last = (k == frame_len - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // Queue a frame given byte by byte
    task automatic queue_bytes(input logic [7:0] data[$]);
        t_frame_item it;
        foreach (data[k]) begin
            it.data = data[k];
            it.last = (k == data.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // Drain all bytes and verdicts, then let the pipeline settle
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the filter mode through the config channel
    task automatic write_mode(input logic [2:0] mode);
        @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_filter_mode <= mode;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        active_mode = mode;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [2:0]  mode_plan[NUM_SETTINGS];
        logic [7:0]  arp_frame[$];
        int          seg_bytes;
        int          seg_frames;
        int          flen;

        mode_plan = '{MODE_HTTP, MODE_ARP, MODE_OFF_LO, MODE_HTTPS, MODE_TCP,
                      MODE_OFF_HI, MODE_DNS, MODE_UDP, MODE_HTTP};

        // Hold reset, then release it at a rising edge
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: the reset mode rejects a one-byte frame outright
        queue_bytes('{8'hFF});
        wait_quiet();

        // Directed: an ARP frame with all-zero and all-one bytes is accepted;
        // a frame ending before the EtherType is flagged short
        write_mode(MODE_ARP);
        for (int k = 0; k < 12; k++) arp_frame.push_back((k % 2) ? 8'hFF : 8'h00);
        arp_frame.push_back(KIND_ARP[15:8]);
        arp_frame.push_back(KIND_ARP[7:0]);
        queue_bytes(arp_frame);
        queue_bytes('{8'h00, 8'hFF});
        wait_quiet();

        write_mode(MODE_TCP);
        queue_bytes('{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h80});
        wait_quiet();

        // Random: one filter mode per phase; sender and receiver idle
        // 28/72, then 72/28, then not at all
        for (int seg = 0; seg < NUM_SETTINGS; seg++) begin
            if (seg < 3) begin
                in_idle_pct  = 28;
                out_idle_pct = 72;
            end else if (seg < 6) begin
                in_idle_pct  = 72;
                out_idle_pct = 28;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            write_mode(mode_plan[seg]);
            seg_bytes  = 0;
            seg_frames = 0;
            while (seg_bytes < SEG_BYTES) begin
                queue_frame(flen);
                seg_bytes += flen;
                seg_frames++;
                // Pause the sender mid-phase until every verdict is back
                if (seg == 3 && seg_frames == 1) wait_quiet();
            end
            wait_quiet();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_verdicts.size() != 0) begin
            $error("verdicts still outstanding: %0d", expected_verdicts.size());
            error_count++;
        end

        $display("Run covered %0d bytes in %0d frames across all filter modes,",
                 bytes_taken, frames_checked);
        $display("with %0d frames accepted and %0d flagged short.", accepts_seen, shorts_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
